// File: hdl/mhpq_pkg.sv
// ----------------------------------------------------------------------------
// Min-heap priority queue package
// Shared sizes, entry type, status codes and the datapath command set.
// ----------------------------------------------------------------------------
package mhpq_pkg;

   localparam int HEAP_DEPTH = 128;
   localparam int ADDR_W     = $clog2(HEAP_DEPTH);
   localparam int KEY_W      = 32;
   localparam int PAY_W      = 16;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 7;

   typedef logic [ADDR_W-1:0]   addr_type;
   typedef logic [ADDR_W:0]     kid_type;
   typedef logic [KEY_W-1:0]    key_type;
   typedef logic [PAY_W-1:0]    pay_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [COUNT_W-1:0]  count_type;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_FULL  = 2'd1;
   localparam status_type ST_EMPTY = 2'd2;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DELETE = 1'b1;

   typedef struct packed {
      key_type key;
      pay_type payload;
   } entry_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_ACCEPT,
      DP_REFUSE,
      DP_INS_START,
      DP_UP_READ,
      DP_UP_STEP,
      DP_UP_PLACE,
      DP_DEL_START,
      DP_DEL_CAPTURE,
      DP_DN_READ,
      DP_DN_STEP,
      DP_DN_PLACE,
      DP_PUBLISH
   } dp_op_type;

   typedef struct packed {
      logic is_delete;
      logic full;
      logic empty;
      logic at_root;
      logic up_move;
      logic dn_leaf;
      logic dn_move;
   } dp_status_type;

endpackage

// File: hdl/mhpq_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one heap operation per item.
// ----------------------------------------------------------------------------
interface mhpq_req_if;
   logic                 valid;
   logic                 ready;
   logic                 operation;
   mhpq_pkg::key_type    new_key;
   mhpq_pkg::pay_type    new_payload;

   modport source (output valid, output operation, output new_key, output new_payload,
                   input ready);
   modport sink   (input valid, input operation, input new_key, input new_payload,
                   output ready);
endinterface

// File: hdl/mhpq_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one result item per operation.
// ----------------------------------------------------------------------------
interface mhpq_rsp_if;
   logic                   valid;
   logic                   ready;
   mhpq_pkg::key_type      out_key;
   mhpq_pkg::pay_type      out_payload;
   mhpq_pkg::status_type   status;
   mhpq_pkg::count_type    entry_count;

   modport source (output valid, output out_key, output out_payload, output status,
                   output entry_count, input ready);
   modport sink   (input valid, input out_key, input out_payload, input status,
                   input entry_count, output ready);
endinterface

// File: hdl/mhpq_datapath.sv
// ----------------------------------------------------------------------------
// Heap datapath
// Entry memory with two registered read ports, sift registers, entry count
// and the result register, driven one command per cycle by the controller.
// ----------------------------------------------------------------------------
module mhpq_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  mhpq_pkg::dp_op_type     dp_op,
   input  logic                    req_operation,
   input  mhpq_pkg::key_type       req_new_key,
   input  mhpq_pkg::pay_type       req_new_payload,
   output mhpq_pkg::dp_status_type dp_status,
   output mhpq_pkg::key_type       rsp_out_key,
   output mhpq_pkg::pay_type       rsp_out_payload,
   output mhpq_pkg::status_type    rsp_status,
   output mhpq_pkg::count_type     rsp_entry_count
);

   mhpq_pkg::entry_type  mem [mhpq_pkg::HEAP_DEPTH];

   mhpq_pkg::entry_type  rd_a_ff, rd_b_ff;
   mhpq_pkg::addr_type   rd_addr_a, rd_addr_b;
   logic                 wr_en;
   mhpq_pkg::addr_type   wr_addr;
   mhpq_pkg::entry_type  wr_data;

   logic                 op_ff, op_in;
   mhpq_pkg::entry_type  mov_ff, mov_in;
   mhpq_pkg::addr_type   pos_ff, pos_in;
   mhpq_pkg::addr_type   hole_ff, hole_in;
   mhpq_pkg::kid_type    kid_ff, kid_in;
   mhpq_pkg::addr_type   count_ff, count_in;
   mhpq_pkg::key_type    res_key_ff, res_key_in;
   mhpq_pkg::pay_type    res_pay_ff, res_pay_in;
   mhpq_pkg::status_type res_status_ff, res_status_in;
   mhpq_pkg::key_type    out_key_ff, out_key_in;
   mhpq_pkg::pay_type    out_pay_ff, out_pay_in;
   mhpq_pkg::status_type out_status_ff, out_status_in;
   mhpq_pkg::count_type  out_count_ff, out_count_in;

   mhpq_pkg::kid_type    count_wide;
   mhpq_pkg::kid_type    kid_plus1;
   logic                 take_right;
   mhpq_pkg::entry_type  pick;
   mhpq_pkg::kid_type    kid_sel;
   logic                 up_move;
   logic                 dn_move;

   assign count_wide = {1'b0, count_ff};
   assign kid_plus1  = kid_ff + 1'b1;

   // The right child is only a candidate when it exists and its key is
   // strictly smaller than the left child's key.
   assign take_right = (kid_ff < count_wide) && (rd_a_ff.key > rd_b_ff.key);
   assign pick       = take_right ? rd_b_ff : rd_a_ff;
   assign kid_sel    = take_right ? kid_plus1 : kid_ff;
   assign up_move    = mov_ff.key < rd_a_ff.key;
   assign dn_move    = !(mov_ff.key < pick.key);

   assign dp_status.is_delete = op_ff;
   assign dp_status.full      = count_ff >= mhpq_pkg::addr_type'(mhpq_pkg::HEAP_DEPTH - 1);
   assign dp_status.empty     = count_ff == '0;
   assign dp_status.at_root   = pos_ff == mhpq_pkg::addr_type'(1);
   assign dp_status.up_move   = up_move;
   assign dp_status.dn_leaf   = kid_ff > count_wide;
   assign dp_status.dn_move   = dn_move;

   always_comb begin
      rd_addr_a     = pos_ff >> 1;
      rd_addr_b     = count_ff;
      wr_en         = 1'b0;
      wr_addr       = pos_ff;
      wr_data       = mov_ff;
      op_in         = op_ff;
      mov_in        = mov_ff;
      pos_in        = pos_ff;
      hole_in       = hole_ff;
      kid_in        = kid_ff;
      count_in      = count_ff;
      res_key_in    = res_key_ff;
      res_pay_in    = res_pay_ff;
      res_status_in = res_status_ff;
      out_key_in    = out_key_ff;
      out_pay_in    = out_pay_ff;
      out_status_in = out_status_ff;
      out_count_in  = out_count_ff;
      unique case (dp_op)
         mhpq_pkg::DP_NOP: begin
         end
         mhpq_pkg::DP_ACCEPT: begin
            op_in          = req_operation;
            mov_in.key     = req_new_key;
            mov_in.payload = req_new_payload;
            res_key_in     = '0;
            res_pay_in     = '0;
            res_status_in  = mhpq_pkg::ST_OK;
         end
         mhpq_pkg::DP_REFUSE: begin
            res_status_in = op_ff ? mhpq_pkg::ST_EMPTY : mhpq_pkg::ST_FULL;
         end
         mhpq_pkg::DP_INS_START: begin
            count_in = count_ff + 1'b1;
            pos_in   = count_ff + 1'b1;
         end
         mhpq_pkg::DP_UP_READ: begin
            rd_addr_a = pos_ff >> 1;
         end
         mhpq_pkg::DP_UP_STEP: begin
            wr_en   = 1'b1;
            wr_addr = pos_ff;
            wr_data = up_move ? rd_a_ff : mov_ff;
            if (up_move) begin
               pos_in = pos_ff >> 1;
            end
         end
         mhpq_pkg::DP_UP_PLACE: begin
            wr_en   = 1'b1;
            wr_addr = pos_ff;
            wr_data = mov_ff;
         end
         mhpq_pkg::DP_DEL_START: begin
            rd_addr_a = mhpq_pkg::addr_type'(1);
            rd_addr_b = count_ff;
            count_in  = count_ff - 1'b1;
            hole_in   = mhpq_pkg::addr_type'(1);
            kid_in    = mhpq_pkg::kid_type'(2);
         end
         mhpq_pkg::DP_DEL_CAPTURE: begin
            res_key_in = rd_a_ff.key;
            res_pay_in = rd_a_ff.payload;
            mov_in     = rd_b_ff;
         end
         mhpq_pkg::DP_DN_READ: begin
            rd_addr_a = kid_ff[mhpq_pkg::ADDR_W-1:0];
            rd_addr_b = kid_plus1[mhpq_pkg::ADDR_W-1:0];
         end
         mhpq_pkg::DP_DN_STEP: begin
            wr_en   = 1'b1;
            wr_addr = hole_ff;
            wr_data = dn_move ? pick : mov_ff;
            if (dn_move) begin
               hole_in = kid_sel[mhpq_pkg::ADDR_W-1:0];
               kid_in  = {kid_sel[mhpq_pkg::ADDR_W-1:0], 1'b0};
            end
         end
         mhpq_pkg::DP_DN_PLACE: begin
            wr_en   = 1'b1;
            wr_addr = hole_ff;
            wr_data = mov_ff;
         end
         mhpq_pkg::DP_PUBLISH: begin
            out_key_in    = res_key_ff;
            out_pay_in    = res_pay_ff;
            out_status_in = res_status_ff;
            out_count_in  = mhpq_pkg::count_type'(count_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      op_ff         <= op_in;
      mov_ff        <= mov_in;
      pos_ff        <= pos_in;
      hole_ff       <= hole_in;
      kid_ff        <= kid_in;
      res_key_ff    <= res_key_in;
      res_pay_ff    <= res_pay_in;
      res_status_ff <= res_status_in;
      out_key_ff    <= out_key_in;
      out_pay_ff    <= out_pay_in;
      out_status_ff <= out_status_in;
      out_count_ff  <= out_count_in;
   end

   assign rsp_out_key     = out_key_ff;
   assign rsp_out_payload = out_pay_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_entry_count = out_count_ff;

endmodule

// File: hdl/mhpq_controller.sv
// ----------------------------------------------------------------------------
// Heap controller
// Sequences insert and delete-min through the datapath and owns the
// handshakes of both channels.
// ----------------------------------------------------------------------------
module mhpq_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  mhpq_pkg::dp_status_type dp_status,
   output mhpq_pkg::dp_op_type     dp_op
);

   typedef enum logic [3:0] {
      IDLE,
      DECIDE,
      UP_CHECK,
      UP_CMP,
      DEL_CAP,
      DN_CHECK,
      DN_CMP,
      FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The output register can take a new result once the old one is gone.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = state_ff == IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      dp_op        = mhpq_pkg::DP_NOP;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               dp_op    = mhpq_pkg::DP_ACCEPT;
               state_in = DECIDE;
            end
         end
         DECIDE: begin
            if (!dp_status.is_delete) begin
               if (dp_status.full) begin
                  dp_op    = mhpq_pkg::DP_REFUSE;
                  state_in = FINISH;
               end else begin
                  dp_op    = mhpq_pkg::DP_INS_START;
                  state_in = UP_CHECK;
               end
            end else begin
               if (dp_status.empty) begin
                  dp_op    = mhpq_pkg::DP_REFUSE;
                  state_in = FINISH;
               end else begin
                  dp_op    = mhpq_pkg::DP_DEL_START;
                  state_in = DEL_CAP;
               end
            end
         end
         UP_CHECK: begin
            if (dp_status.at_root) begin
               dp_op    = mhpq_pkg::DP_UP_PLACE;
               state_in = FINISH;
            end else begin
               dp_op    = mhpq_pkg::DP_UP_READ;
               state_in = UP_CMP;
            end
         end
         UP_CMP: begin
            dp_op    = mhpq_pkg::DP_UP_STEP;
            state_in = dp_status.up_move ? UP_CHECK : FINISH;
         end
         DEL_CAP: begin
            dp_op    = mhpq_pkg::DP_DEL_CAPTURE;
            state_in = DN_CHECK;
         end
         DN_CHECK: begin
            if (dp_status.dn_leaf) begin
               dp_op    = mhpq_pkg::DP_DN_PLACE;
               state_in = FINISH;
            end else begin
               dp_op    = mhpq_pkg::DP_DN_READ;
               state_in = DN_CMP;
            end
         end
         DN_CMP: begin
            dp_op    = mhpq_pkg::DP_DN_STEP;
            state_in = dp_status.dn_move ? DN_CHECK : FINISH;
         end
         FINISH: begin
            if (out_free) begin
               dp_op        = mhpq_pkg::DP_PUBLISH;
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: hdl/min_heap_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// Min-heap priority queue unit
// Binary min-heap of key/payload entries with insert and delete-min.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan takes one item per operation: operation selects insert or
//   delete-min, new_key and new_payload give the entry to insert.
//   rsp_chan returns exactly one item per request: the removed minimum (zero
//   for an insert), a status code and the entry count after the operation.
//   Inserts into a full heap and deletes from an empty heap are refused with
//   a status code and leave the heap unchanged.
// Sequencing:
//   An insert moves the new entry up one level per compare step until its
//   parent's key is no larger or it reaches the root. A delete-min moves
//   the last entry down the same way until both children hold larger keys
//   or it reaches a leaf. A refused operation skips the sift. The next item
//   can be accepted as soon as the result is offered, so the unit works on
//   one item at a time.
// Reset and stalls:
//   Reset empties the heap at once; memory contents need no clearing. A
//   finished result sits in the output register while the next item is
//   accepted and processed; a new result waits until the old one is taken.
// ----------------------------------------------------------------------------
module min_heap_priority_queue_unit (
   input  logic        clock,
   input  logic        reset,
   mhpq_req_if.sink    req_chan,
   mhpq_rsp_if.source  rsp_chan
);

   mhpq_pkg::dp_op_type     dp_op;
   mhpq_pkg::dp_status_type dp_status;

   mhpq_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .dp_status (dp_status),
      .dp_op     (dp_op)
   );

   mhpq_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .dp_op           (dp_op),
      .req_operation   (req_chan.operation),
      .req_new_key     (req_chan.new_key),
      .req_new_payload (req_chan.new_payload),
      .dp_status       (dp_status),
      .rsp_out_key     (rsp_chan.out_key),
      .rsp_out_payload (rsp_chan.out_payload),
      .rsp_status      (rsp_chan.status),
      .rsp_entry_count (rsp_chan.entry_count)
   );

endmodule

// File: hdl/mhpq_checker.sv
// ----------------------------------------------------------------------------
// Min-heap priority queue checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module mhpq_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input mhpq_pkg::key_type    rsp_out_key,
   input mhpq_pkg::pay_type    rsp_out_payload,
   input mhpq_pkg::status_type rsp_status,
   input mhpq_pkg::count_type  rsp_entry_count
);

   // A result that is not taken stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // A refused operation never carries an entry.
   a_refuse_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != mhpq_pkg::ST_OK |->
         rsp_out_key == '0 && rsp_out_payload == '0)
      else $error("refused operation returned an entry");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == mhpq_pkg::ST_FULL |->
         rsp_entry_count == mhpq_pkg::count_type'(mhpq_pkg::HEAP_DEPTH - 1))
      else $error("full refusal with heap not full");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == mhpq_pkg::ST_EMPTY |-> rsp_entry_count == '0)
      else $error("empty refusal with entries held");

endmodule

bind min_heap_priority_queue_unit mhpq_checker u_mhpq_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_out_key     (rsp_chan.out_key),
   .rsp_out_payload (rsp_chan.out_payload),
   .rsp_status      (rsp_chan.status),
   .rsp_entry_count (rsp_chan.entry_count)
);
